>>> rtl/nearest_point_snap_unit_assert.svh
// Assertion macros for the nearest point snap unit.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef NEAREST_POINT_SNAP_UNIT_ASSERT_SVH
`define NEAREST_POINT_SNAP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nps_pkg.sv
// Shared types and constants for the nearest point snap unit.
// No dependencies.
package nps_pkg;

  localparam int MAX_POINTS = 1024;

  localparam int COORD_X_W = 29;
  localparam int COORD_Y_W = 28;
  localparam int RADIUS_W  = 29;
  localparam int STATUS_W  = 3;
  localparam int FUNC_W    = 2;
  localparam int DIST_W    = 59;

  // half and full turn in 2^-20 degree units, sized for the 30 bit difference
  localparam logic signed [COORD_X_W:0] DEG180 = 30'sd188743680;
  localparam logic signed [COORD_X_W:0] DEG360 = 30'sd377487360;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_SNAPPED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_POINT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic found;
  } pipe_status_t;

endpackage

>>> rtl/nps_point_mem.sv
// Point table: one write port, one read port with registered read data.
// Uses nothing from the package.
module nps_point_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 57,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/nps_dist_pipe.sv
// Distance pipeline: wrapped difference, squares, running minimum against the radius.
// Depends on nps_pkg.
module nps_dist_pipe (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [nps_pkg::RADIUS_W-1:0]          radius,
  input  logic signed [nps_pkg::COORD_X_W-1:0]  qx,
  input  logic signed [nps_pkg::COORD_Y_W-1:0]  qy,
  input  logic                                  rd_en,
  input  logic signed [nps_pkg::COORD_X_W-1:0]  pt_x,
  input  logic signed [nps_pkg::COORD_Y_W-1:0]  pt_y,
  output nps_pkg::pipe_status_t                 stat,
  output logic signed [nps_pkg::COORD_X_W-1:0]  best_x,
  output logic signed [nps_pkg::COORD_Y_W-1:0]  best_y
);

  localparam int XW = nps_pkg::COORD_X_W;
  localparam int YW = nps_pkg::COORD_Y_W;
  localparam int DW = nps_pkg::DIST_W;
  localparam int RW = nps_pkg::RADIUS_W;
  localparam int UXW = XW - 1;
  localparam int UYW = YW + 1;

  logic v0, va, vb, vc;
  logic found;
  logic [DW-1:0] best;
  logic [2*RW-1:0] radius_sq;

  logic signed [XW:0]   dx_a;
  logic signed [YW:0]   dy_a;
  logic signed [XW-1:0] x_a, x_b, x_c;
  logic signed [YW-1:0] y_a, y_b, y_c;
  logic [UXW-1:0] ux_b;
  logic [UYW-1:0] uy_b;
  logic [2*UXW-1:0] sqx_c;
  logic [2*UYW-1:0] sqy_c;

  logic signed [XW:0] dx_wrap, dx_abs;
  logic signed [YW:0] dy_abs;
  logic [DW-1:0] cand_dist;

  // at most one turn is needed for any 30 bit difference
  always_comb begin
    if (dx_a > nps_pkg::DEG180) begin
      dx_wrap = dx_a - nps_pkg::DEG360;
    end else if (dx_a < -nps_pkg::DEG180) begin
      dx_wrap = dx_a + nps_pkg::DEG360;
    end else begin
      dx_wrap = dx_a;
    end
    dx_abs = dx_wrap[XW] ? -dx_wrap : dx_wrap;
    dy_abs = dy_a[YW] ? -dy_a : dy_a;
  end

  assign radius_sq = radius * radius;
  assign cand_dist = DW'(sqx_c) + DW'(sqy_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      found <= 1'b0;
    end else begin
      v0 <= rd_en;
      va <= v0;
      vb <= va;
      vc <= vb;
      if (start) begin
        found <= 1'b0;
      end else if (vc && cand_dist < best) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_a <= {qx[XW-1], qx} - {pt_x[XW-1], pt_x};
    dy_a <= {qy[YW-1], qy} - {pt_y[YW-1], pt_y};
    x_a  <= pt_x;
    y_a  <= pt_y;
    ux_b <= dx_abs[UXW-1:0];
    uy_b <= dy_abs[UYW-1:0];
    x_b  <= x_a;
    y_b  <= y_a;
    sqx_c <= ux_b * ux_b;
    sqy_c <= uy_b * uy_b;
    x_c  <= x_b;
    y_c  <= y_b;
    if (start) begin
      best <= DW'(radius_sq);
    end else if (vc && cand_dist < best) begin
      // strict compare keeps the first of equal candidates
      best   <= cand_dist;
      best_x <= x_c;
      best_y <= y_c;
    end
  end

  assign stat.busy  = v0 | va | vb | vc;
  assign stat.found = found;

endmodule

>>> rtl/nearest_point_snap_unit.sv
// Nearest point snap unit: a load or clear request goes straight to the result slot; a query
// scans the point table through its single read port one entry per cycle, then waits for the
// distance pipeline to drain before its result passes through the result slot and the output
// register; a query on an empty table skips the scan. The table needs no clearing pass after
// reset; only entries below the fill count are read.
// Depends on nps_pkg, nps_point_mem, nps_dist_pipe and nearest_point_snap_unit_assert.svh.
`include "nearest_point_snap_unit_assert.svh"

module nearest_point_snap_unit #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [28:0] cfg_data,    // snap_radius
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,     // [28:0] coord_x, [56:29] coord_y, rest zero
  input  logic [1:0]  s_tuser,     // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // [28:0] out_x, [56:29] out_y, rest zero
  output logic [2:0]  m_tuser      // [2:0] status
);

  localparam int XW = nps_pkg::COORD_X_W;
  localparam int YW = nps_pkg::COORD_Y_W;
  localparam int SW = nps_pkg::STATUS_W;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  nps_pkg::state_t state, state_next;
  nps_pkg::pipe_status_t pipe_stat;

  logic [nps_pkg::RADIUS_W-1:0] snap_radius;
  logic [CW-1:0] point_count;
  logic [CW-1:0] scan_idx;
  logic signed [XW-1:0] qx;
  logic signed [YW-1:0] qy;

  logic          res_valid;
  logic [SW-1:0] res_status;
  logic [XW-1:0] res_x;
  logic [YW-1:0] res_y;

  logic accept, is_query, scan_last, drain_done, rd_en, wr_en, start, table_full;
  logic [XW+YW-1:0] rd_data;
  logic signed [XW-1:0] best_x, in_x;
  logic signed [YW-1:0] best_y, in_y;

  assign in_x       = s_tdata[XW-1:0];
  assign in_y       = s_tdata[XW+YW-1:XW];
  assign accept     = s_tvalid && s_tready;
  assign is_query   = s_tuser == nps_pkg::FUNC_QUERY;
  assign table_full = point_count == CW'(MAX_POINTS);
  assign scan_last  = (scan_idx + CW'(1)) == point_count;
  assign drain_done = !pipe_stat.busy;
  assign wr_en      = accept && (s_tuser == nps_pkg::FUNC_LOAD) && !table_full;
  assign start      = accept && is_query;
  assign cfg_ready  = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      nps_pkg::S_IDLE: begin
        if (start && point_count != '0) begin
          state_next = nps_pkg::S_SCAN;
        end
      end
      nps_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = nps_pkg::S_DRAIN;
        end
      end
      nps_pkg::S_DRAIN: begin
        if (drain_done) begin
          state_next = nps_pkg::S_IDLE;
        end
      end
      default: state_next = nps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    unique case (state)
      nps_pkg::S_IDLE:  s_tready = !res_valid;
      nps_pkg::S_SCAN:  rd_en = 1'b1;
      nps_pkg::S_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= nps_pkg::S_IDLE;
      snap_radius <= '0;
      point_count <= '0;
      scan_idx    <= '0;
      res_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        snap_radius <= cfg_data;
      end
      if (wr_en) begin
        point_count <= point_count + CW'(1);
      end else if (accept && s_tuser == nps_pkg::FUNC_CLEAR) begin
        point_count <= '0;
      end
      if (start) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + CW'(1);
      end
      // result slot: filled by a finished request, drained into the output register
      if (accept && s_tuser != nps_pkg::FUNC_UNUSED) begin
        res_valid <= !(is_query && point_count != '0);
      end else if (state == nps_pkg::S_DRAIN && drain_done) begin
        res_valid <= 1'b1;
      end else if (res_valid && (!m_tvalid || m_tready)) begin
        res_valid <= 1'b0;
      end
      if (res_valid && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx <= in_x;
      qy <= in_y;
    end
    if (accept) begin
      res_x <= '0;
      res_y <= '0;
      priority case (1'b1)
        is_query: begin
          res_status <= nps_pkg::ST_NO_POINT;
          res_x      <= in_x;
          res_y      <= in_y;
        end
        s_tuser == nps_pkg::FUNC_CLEAR: res_status <= nps_pkg::ST_CLEARED;
        table_full: res_status <= nps_pkg::ST_DROPPED;
        default: res_status <= nps_pkg::ST_STORED;
      endcase
    end else if (state == nps_pkg::S_DRAIN && drain_done) begin
      if (pipe_stat.found) begin
        res_status <= nps_pkg::ST_SNAPPED;
        res_x      <= best_x;
        res_y      <= best_y;
      end else begin
        res_status <= nps_pkg::ST_NO_POINT;
        res_x      <= qx;
        res_y      <= qy;
      end
    end
    if (res_valid && (!m_tvalid || m_tready)) begin
      m_tdata <= {{(64 - XW - YW){1'b0}}, res_y, res_x};
      m_tuser <= res_status;
    end
  end

  nps_point_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (XW + YW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (point_count[AW-1:0]),
    .wr_data ({in_y, in_x}),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  nps_dist_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .radius (snap_radius),
    .qx     (qx),
    .qy     (qy),
    .rd_en  (rd_en),
    .pt_x   (rd_data[XW-1:0]),
    .pt_y   (rd_data[XW+YW-1:XW]),
    .stat   (pipe_stat),
    .best_x (best_x),
    .best_y (best_y)
  );

  `NPS_ASSERT_NOW(a_count_bound, 1'b1, point_count <= CW'(MAX_POINTS), "point count overflow")
  `NPS_ASSERT_NOW(a_read_in_table, rd_en, scan_idx < point_count, "scan read past fill count")
  `NPS_ASSERT_NEXT(a_query_scans, start && point_count != '0, state == nps_pkg::S_SCAN,
                   "query did not start scan")
  `NPS_ASSERT_NEXT(a_drain_result, state == nps_pkg::S_DRAIN && drain_done, res_valid,
                   "query result lost")

endmodule
